FILE: sv/synchronous_vector_averaging_server_assert.svh
// assertion macros used by the rtl of the averaging server
// clk and rst are taken from the scope where a macro is used
`ifndef SYNCHRONOUS_VECTOR_AVERAGING_SERVER_ASSERT_SVH
`define SYNCHRONOUS_VECTOR_AVERAGING_SERVER_ASSERT_SVH

// same-cycle implication
`define SVAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never hold
`define SVAS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

FILE: sv/svas_pkg.sv
// ----------------------------------------------------------------------------
// svas_pkg
// shared constants, types and codes of the vector averaging server
// ----------------------------------------------------------------------------
`default_nettype none

package svas_pkg;

  // sizing
  localparam int NUM_CLIENTS  = 2;
  localparam int VECTOR_DEPTH = 4096;
  localparam int ADDR_W       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  // field widths
  localparam int INDEX_W = 12;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 36;
  localparam int CNT_W   = 5;

  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  // saturation limits
  localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W:0] AVG_MAX = (SUM_W+1)'({1'b0, {(VALUE_W-1){1'b1}}});
  localparam logic signed [SUM_W:0] AVG_MIN = -AVG_MAX - (SUM_W+1)'(1);

  // item action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  // result status codes
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_WRONG_PHASE = 1'b1;

endpackage

`default_nettype wire

FILE: sv/svas_req_if.sv
// ----------------------------------------------------------------------------
// svas_req_if
// request channel: one vector element per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface svas_req_if;
  import svas_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [INDEX_W-1:0]  index;
  value_t              value;
  logic                last;

  modport source (output valid, action, index, value, last, input ready);
  modport sink   (input valid, action, index, value, last, output ready);
endinterface

`default_nettype wire

FILE: sv/svas_rsp_if.sv
// ----------------------------------------------------------------------------
// svas_rsp_if
// response channel: one result per accepted request
// ----------------------------------------------------------------------------
`default_nettype none

interface svas_rsp_if;
  import svas_pkg::*;

  logic    valid;
  logic    ready;
  logic    status;
  value_t  average;
  logic    phase_done;

  modport source (output valid, status, average, phase_done, input ready);
  modport sink   (input valid, status, average, phase_done, output ready);
endinterface

`default_nettype wire

FILE: sv/svas_ram.sv
// ----------------------------------------------------------------------------
// svas_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module svas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/svas_div.sv
// ----------------------------------------------------------------------------
// svas_div
// unsigned divide by NUM_CLIENTS, result registered in the cycle after start
// ----------------------------------------------------------------------------
`default_nettype none

module svas_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [svas_pkg::SUM_W-1:0]  dividend,
  output logic                             done,
  output logic      [svas_pkg::SUM_W-1:0]  quotient
);
  import svas_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    // constant power-of-two divisor, a plain shift in hardware
    if (start) begin
      quotient <= dividend / SUM_W'(NUM_CLIENTS);
    end
  end

endmodule

`default_nettype wire

FILE: sv/synchronous_vector_averaging_server.sv
// ----------------------------------------------------------------------------
// synchronous_vector_averaging_server
// synchronous push/pull averaging of vectors from NUM_CLIENTS clients
// ----------------------------------------------------------------------------
// Clients stream vector elements, one per request transfer. In the push phase
// each pushed Q16.16 value is added (saturating at 36 bits) into the sum ram
// entry picked by index. After NUM_CLIENTS pushes ending with last = 1 the
// block turns to the pull phase, where each pull returns sum / NUM_CLIENTS,
// truncated toward zero and saturated to 32 bits. After NUM_CLIENTS pulls end
// the store reads as zero again and pushing resumes. A request of the wrong
// phase is answered with status 1 and leaves the state alone. Exactly one
// response transfer follows every request transfer. The block handles one
// element at a time through a read-modify-write on the sum ram: a push passes
// through S_READ and S_OUT, a rejected request goes straight to S_OUT and a
// pull passes through S_READ, S_DIV and S_OUT, the division by NUM_CLIENTS
// being registered. A stalled sink holds the block in S_OUT until the output
// register frees. Every entry carries a round tag in a tag ram; after reset
// and after each completed pull phase a sweep rewrites all VECTOR_DEPTH tags
// while no request is taken. A finished response sits in the output register
// so the next request can be taken before the sink takes it.
`default_nettype none

module synchronous_vector_averaging_server (
  input  wire logic   clk,
  input  wire logic   rst,
  svas_req_if.sink    req,
  svas_rsp_if.source  rsp
);
  import svas_pkg::*;

  `include "synchronous_vector_averaging_server_assert.svh"

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  // global control state
  logic              current_round;
  logic              pull_phase;
  logic [CNT_W-1:0]  push_cnt;
  logic [CNT_W-1:0]  pull_cnt;
  logic [ADDR_W-1:0] clr_cnt;

  // item in flight
  logic               it_action;
  logic [INDEX_W-1:0] it_index;
  value_t             it_value;
  logic               it_last;
  logic               it_in_range;
  logic               it_neg;

  // staged result
  logic   res_status;
  value_t res_avg;

  // output register
  logic   out_valid;
  logic   out_status;
  value_t out_avg;
  logic   out_done;

  // ram ports
  logic              sum_we;
  logic              tag_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              tag_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  sum_t              sum_rdata;
  logic              tag_rdata;

  // datapath
  logic                   accept;
  logic                   out_free;
  logic                   out_load;
  sum_t                   entry;
  logic signed [SUM_W:0]  push_wide;
  sum_t                   push_sum;
  logic [SUM_W-1:0]       entry_mag;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quo;
  logic signed [SUM_W:0]  quo_signed;
  value_t                 avg_sat;
  logic [CNT_W-1:0]       cnt_inc;
  logic                   phase_end;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign out_load  = (state == S_OUT) && out_free;

  // read is issued at the request transfer, data shows in S_READ
  assign mem_raddr = ADDR_W'(req.index);

  // an entry whose tag is from an older round reads as zero
  assign entry = (it_in_range && (tag_rdata == current_round)) ? sum_rdata : '0;

  // saturating accumulate
  assign push_wide = {entry[SUM_W-1], entry} + (SUM_W+1)'(it_value);
  always_comb begin
    if (push_wide > SUM_MAX) begin
      push_sum = SUM_W'(SUM_MAX);
    end else if (push_wide < SUM_MIN) begin
      push_sum = SUM_W'(SUM_MIN);
    end else begin
      push_sum = push_wide[SUM_W-1:0];
    end
  end

  // write back the push, or sweep the tags
  always_comb begin
    sum_we    = 1'b0;
    tag_we    = 1'b0;
    mem_waddr = ADDR_W'(it_index);
    tag_wdata = current_round;
    if (state == S_CLEAR) begin
      tag_we    = 1'b1;
      mem_waddr = clr_cnt;
      tag_wdata = ~current_round;
    end else if (state == S_READ && it_action == ACT_PUSH && it_in_range) begin
      sum_we = 1'b1;
      tag_we = 1'b1;
    end
  end

  // divide the magnitude so the quotient truncates toward zero
  assign entry_mag = entry[SUM_W-1] ? SUM_W'(-entry) : SUM_W'(entry);
  assign div_start = (state == S_READ) && (it_action == ACT_PULL);

  assign quo_signed = it_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  always_comb begin
    if (quo_signed > AVG_MAX) begin
      avg_sat = VALUE_W'(AVG_MAX);
    end else if (quo_signed < AVG_MIN) begin
      avg_sat = VALUE_W'(AVG_MIN);
    end else begin
      avg_sat = quo_signed[VALUE_W-1:0];
    end
  end

  // client count for the phase of the item in flight
  assign cnt_inc   = ((it_action == ACT_PULL) ? pull_cnt : push_cnt) + CNT_W'(1);
  assign phase_end = (res_status == STATUS_OK) && it_last
                  && (cnt_inc >= CNT_W'(NUM_CLIENTS));

  svas_ram #(
    .WIDTH (SUM_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (mem_waddr),
    .wdata (push_sum),
    .raddr (mem_raddr),
    .rdata (sum_rdata)
  );

  svas_ram #(
    .WIDTH (1),
    .DEPTH (VECTOR_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (mem_waddr),
    .wdata (tag_wdata),
    .raddr (mem_raddr),
    .rdata (tag_rdata)
  );

  svas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (entry_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      current_round <= 1'b1;
      pull_phase    <= 1'b0;
      push_cnt      <= '0;
      pull_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      // output register: reload wins over a drain in the same cycle
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == ADDR_W'(VECTOR_DEPTH - 1)) begin
            clr_cnt <= '0;
            state   <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            it_action   <= req.action;
            it_index    <= req.index;
            it_value    <= req.value;
            it_last     <= req.last;
            it_in_range <= (32'(req.index) < VECTOR_DEPTH);
            res_avg     <= '0;
            if (req.action != pull_phase) begin
              res_status <= STATUS_WRONG_PHASE;
              state      <= S_OUT;
            end else begin
              res_status <= STATUS_OK;
              state      <= S_READ;
            end
          end
        end
        S_READ: begin
          it_neg <= entry[SUM_W-1];
          if (it_action == ACT_PULL) begin
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_avg <= avg_sat;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_status <= res_status;
            out_avg    <= res_avg;
            out_done   <= phase_end;
            if ((res_status == STATUS_OK) && it_last) begin
              if (it_action == ACT_PULL) begin
                pull_cnt <= phase_end ? '0 : cnt_inc;
              end else begin
                push_cnt <= phase_end ? '0 : cnt_inc;
              end
            end
            if (phase_end && (it_action == ACT_PULL)) begin
              // new round: every tag is stale after the sweep
              current_round <= ~current_round;
              pull_phase    <= 1'b0;
              state         <= S_CLEAR;
            end else begin
              if (phase_end) begin
                pull_phase <= 1'b1;
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.average    = out_avg;
  assign rsp.phase_done = out_done;

  // no request is taken during the tag sweep
  `SVAS_ASSERT_NEVER(a_no_accept_in_clear, (state == S_CLEAR) && accept, "accept during sweep")

  // a rejected response carries no average and no phase end
  `SVAS_ASSERT_IMP(a_reject_clean, out_valid && (out_status == STATUS_WRONG_PHASE), (out_avg == '0) && !out_done, "rejected response not clean")

  // completing a phase flips the phase
  `SVAS_ASSERT_NEXT(a_phase_flips, (state == S_OUT) && out_free && phase_end, pull_phase != $past(pull_phase), "phase did not flip")

  // the divider only answers while a pull waits for it
  `SVAS_ASSERT_IMP(a_div_done_in_div, div_done, state == S_DIV, "divider done outside S_DIV")

  // the ram is never written for an item of the wrong phase
  `SVAS_ASSERT_IMP(a_no_write_on_reject, sum_we, (state == S_READ) && (res_status == STATUS_OK), "write on rejected item")

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the synchronous vector averaging server
// ----------------------------------------------------------------------------
// A short table of hand-picked elements comes first: wrong-phase requests,
// saturation of the average at both ends, truncation toward zero, unwritten
// entries and the store clear between rounds. Rows whose result is obvious
// carry it inline. Every other row, and all of the random traffic, is checked
// against a behavioral predictor of the server. The random part runs whole
// rounds (push vectors from every client, then pull vectors over the same
// index window) with stray wrong-phase requests mixed in. Now and then a round
// hammers one entry with extreme values to drive the 36-bit sum into
// saturation. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import svas_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int IDLE_LIMIT   = 20000;  // covers the tag sweep of all VECTOR_DEPTH entries
  localparam int DRAIN_CYCLES = 32;
  localparam int ROW_COUNT    = 24;

  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint AVG_HI = (longint'(1) <<< (VALUE_W - 1)) - 1;
  localparam longint AVG_LO = -AVG_HI - 1;

  typedef struct packed {
    logic               action;
    logic [INDEX_W-1:0] index;
    value_t             value;
    logic               last;
  } element_t;

  typedef struct packed {
    logic   status;
    value_t average;
    logic   phase_done;
  } result_t;

  typedef struct packed {
    element_t elem;
    logic     typed;   // want holds the result to check
    result_t  want;
  } row_t;

  localparam value_t  V_MAX         = 32'sh7FFF_FFFF;
  localparam value_t  V_MIN         = 32'sh8000_0000;
  localparam result_t ACCEPTED      = '{STATUS_OK, 32'sd0, 1'b0};
  localparam result_t ACCEPTED_DONE = '{STATUS_OK, 32'sd0, 1'b1};
  localparam result_t REJECTED      = '{STATUS_WRONG_PHASE, 32'sd0, 1'b0};
  localparam result_t UNTYPED       = '0;

  // directed stimulus; untyped rows go through the predictor
  localparam row_t DIRECTED_ROWS [ROW_COUNT] = '{
    // pull while pushing
    '{'{ACT_PULL, 12'd0,    32'sd0,  1'b0}, 1'b1, REJECTED},
    // three max pushes into entry 0, three min pushes into the top entry
    '{'{ACT_PUSH, 12'd0,    V_MAX,   1'b0}, 1'b1, ACCEPTED},
    '{'{ACT_PUSH, 12'd0,    V_MAX,   1'b0}, 1'b0, UNTYPED},
    '{'{ACT_PUSH, 12'd0,    V_MAX,   1'b0}, 1'b0, UNTYPED},
    '{'{ACT_PUSH, 12'd4095, V_MIN,   1'b0}, 1'b0, UNTYPED},
    '{'{ACT_PUSH, 12'd4095, V_MIN,   1'b0}, 1'b0, UNTYPED},
    '{'{ACT_PUSH, 12'd4095, V_MIN,   1'b1}, 1'b1, ACCEPTED},
    // odd sums, two of them negative, for truncation toward zero
    '{'{ACT_PUSH, 12'd1,    -32'sd3, 1'b0}, 1'b0, UNTYPED},
    '{'{ACT_PUSH, 12'd2,    -32'sd1, 1'b0}, 1'b0, UNTYPED},
    '{'{ACT_PUSH, 12'd3,    32'sd5,  1'b1}, 1'b1, ACCEPTED_DONE},
    // push while pulling
    '{'{ACT_PUSH, 12'd7,    V_MAX,   1'b1}, 1'b1, REJECTED},
    // averages past the 32-bit range saturate; pull value is ignored
    '{'{ACT_PULL, 12'd0,    32'sh1234, 1'b0}, 1'b1, '{STATUS_OK, V_MAX, 1'b0}},
    '{'{ACT_PULL, 12'd4095, V_MIN,   1'b0}, 1'b1, '{STATUS_OK, V_MIN, 1'b0}},
    '{'{ACT_PULL, 12'd1,    32'sd0,  1'b0}, 1'b0, UNTYPED},
    '{'{ACT_PULL, 12'd2,    32'sd0,  1'b0}, 1'b0, UNTYPED},
    '{'{ACT_PULL, 12'd3,    32'sd0,  1'b0}, 1'b0, UNTYPED},
    // entry never pushed this round
    '{'{ACT_PULL, 12'd100,  32'sd0,  1'b0}, 1'b1, ACCEPTED},
    '{'{ACT_PULL, 12'd0,    32'sd0,  1'b1}, 1'b0, UNTYPED},
    '{'{ACT_PULL, 12'd4095, 32'sd0,  1'b1}, 1'b1, '{STATUS_OK, V_MIN, 1'b1}},
    // back in the push phase; old sums must be gone
    '{'{ACT_PULL, 12'd0,    32'sd0,  1'b0}, 1'b1, REJECTED},
    '{'{ACT_PUSH, 12'd0,    32'sd0,  1'b1}, 1'b1, ACCEPTED},
    '{'{ACT_PUSH, 12'd0,    32'sd1,  1'b1}, 1'b1, ACCEPTED_DONE},
    '{'{ACT_PULL, 12'd0,    32'sd0,  1'b1}, 1'b0, UNTYPED},
    '{'{ACT_PULL, 12'd3,    32'sd0,  1'b1}, 1'b1, ACCEPTED_DONE}
  };

  logic clk = 1'b0;
  logic rst;

  svas_req_if req ();
  svas_rsp_if rsp ();

  synchronous_vector_averaging_server i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: sums with per-entry round tags, as the server keeps them
  longint  acc_sum [VECTOR_DEPTH];
  bit      acc_tag [VECTOR_DEPTH];
  bit      acc_round     = 1'b1;
  bit      in_pull_phase = 1'b0;
  int      pushes_ended  = 0;
  int      pulls_ended   = 0;

  result_t awaited_results [$];
  int      elements_sent = 0;
  int      mismatches    = 0;
  int      idle_count    = 0;
  bit      req_quiet     = 1'b0;
  bit      rsp_quiet     = 1'b0;
  int      rsp_stall     = 0;

  initial begin
    foreach (acc_tag[i]) acc_tag[i] = 1'b0;
  end

  // sum seen at an entry; stale round tags read as zero
  function automatic longint entry_sum(logic [INDEX_W-1:0] idx);
    if (idx >= VECTOR_DEPTH) return 0;
    if (acc_tag[idx] != acc_round) return 0;
    return acc_sum[idx];
  endfunction

  // result of one element, advancing the predictor state
  function automatic result_t averaged_result_for(element_t e);
    result_t r;
    longint  s;
    r = ACCEPTED;
    if (e.action != (in_pull_phase ? ACT_PULL : ACT_PUSH)) begin
      r.status = STATUS_WRONG_PHASE;
    end else if (e.action == ACT_PUSH) begin
      if (e.index < VECTOR_DEPTH) begin
        s = entry_sum(e.index) + longint'(e.value);
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        acc_sum[e.index] = s;
        acc_tag[e.index] = acc_round;
      end
      if (e.last) begin
        pushes_ended = (pushes_ended + 1) & ((1 << CNT_W) - 1);
        if (pushes_ended >= NUM_CLIENTS) begin
          pushes_ended  = 0;
          in_pull_phase = 1'b1;
          r.phase_done  = 1'b1;
        end
      end
    end else begin
      // longint division truncates toward zero
      s = entry_sum(e.index) / NUM_CLIENTS;
      if (s > AVG_HI) s = AVG_HI;
      if (s < AVG_LO) s = AVG_LO;
      r.average = value_t'(s);
      if (e.last) begin
        pulls_ended = (pulls_ended + 1) & ((1 << CNT_W) - 1);
        if (pulls_ended >= NUM_CLIENTS) begin
          pulls_ended   = 0;
          in_pull_phase = 1'b0;
          acc_round     = ~acc_round;
          foreach (acc_tag[i]) acc_tag[i] = ~acc_round;
          r.phase_done  = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int idle_cycles(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic value_t pushed_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return value_t'($urandom_range(0, 64)) - 32'sd32;
    if (r < 25) begin
      case ($urandom_range(0, 3))
        0: return V_MAX;
        1: return V_MIN;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return value_t'($urandom());
  endfunction

  // request of the wrong phase with random content
  function automatic element_t stray_element(logic act);
    element_t e;
    e.action = act;
    e.index  = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
    e.value  = value_t'($urandom());
    e.last   = 1'(($urandom_range(0, 1)));
    return e;
  endfunction

  // one request transfer; the expectation is queued at acceptance
  task automatic transfer_element(element_t e, logic typed, result_t want);
    int gap;
    result_t predicted;
    gap = idle_cycles(req_quiet);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.action <= e.action;
    req.index  <= e.index;
    req.value  <= e.value;
    req.last   <= e.last;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = averaged_result_for(e);
    awaited_results.push_back(typed ? want : predicted);
    elements_sent++;
  endtask

  // one full round: push vectors from every client, then pull vectors
  task automatic run_round();
    int       base;
    int       len;
    int       r;
    bit       hammer;
    value_t   hammer_value;
    element_t e;
    req_quiet    = ($urandom_range(0, 4) == 0);
    rsp_quiet    = ($urandom_range(0, 4) == 0);
    r            = $urandom_range(0, 9);
    base         = (r == 0) ? 0 :
                   (r == 1) ? VECTOR_DEPTH - 16 : $urandom_range(0, VECTOR_DEPTH - 16);
    hammer       = ($urandom_range(0, 7) == 0);
    hammer_value = $urandom_range(0, 1) ? V_MAX : V_MIN;

    for (int c = 0; c < NUM_CLIENTS; c++) begin
      len = hammer ? $urandom_range(16, 24) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0)
          transfer_element(stray_element(ACT_PULL), 1'b0, UNTYPED);
        e.action = ACT_PUSH;
        if (hammer)
          e.index = INDEX_W'(base);
        else if ($urandom_range(0, 9) == 0)
          e.index = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
        else
          e.index = INDEX_W'(base + $urandom_range(0, 15));
        e.value = hammer ? hammer_value : pushed_value();
        e.last  = (k == len - 1);
        transfer_element(e, 1'b0, UNTYPED);
      end
    end

    for (int c = 0; c < NUM_CLIENTS; c++) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0)
          transfer_element(stray_element(ACT_PUSH), 1'b0, UNTYPED);
        e.action = ACT_PULL;
        if ($urandom_range(0, 9) == 0)
          e.index = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
        else
          e.index = INDEX_W'(base + (hammer ? 0 : $urandom_range(0, 15)));
        e.value = value_t'($urandom());
        e.last  = (k == len - 1);
        transfer_element(e, 1'b0, UNTYPED);
      end
    end
  endtask

  // response sink with random stalls
  always @(posedge clk) begin
    if (rsp_stall > 0) begin
      rsp.ready <= 1'b0;
      rsp_stall = rsp_stall - 1;
    end else begin
      rsp.ready <= 1'b1;
      rsp_stall = idle_cycles(rsp_quiet);
    end
  end

  // compare every response transfer with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (awaited_results.size() == 0) begin
        $error("response transfer with no request outstanding");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatches++;
        end
        if (rsp.average !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, rsp.average);
          mismatches++;
        end
        if (rsp.phase_done !== want.phase_done) begin
          $error("phase_done: expected %0d, got %0d", want.phase_done, rsp.phase_done);
          mismatches++;
        end
      end
    end
  end

  // hang detection: cycles without a transfer on either channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    rst        = 1'b1;
    req.valid  = 1'b0;
    req.action = ACT_PUSH;
    req.index  = '0;
    req.value  = '0;
    req.last   = 1'b0;
    rsp.ready  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      transfer_element(DIRECTED_ROWS[i].elem, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    while (elements_sent < ROW_COUNT + RANDOM_ITEMS) run_round();

    req.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/svas_pkg.sv
sv/svas_req_if.sv
sv/svas_rsp_if.sv
sv/svas_ram.sv
sv/svas_div.sv
sv/synchronous_vector_averaging_server.sv
sim/tb_top.sv
